@@ rtl/core/column_gap_character_segmenter_unit_defines.svh @@
// ----------------------------------------------------------------------------
// Column gap character segmenter: assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef COLUMN_GAP_CHARACTER_SEGMENTER_UNIT_DEFINES_SVH
`define COLUMN_GAP_CHARACTER_SEGMENTER_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CGCS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CGCS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/core/cgcs_pkg.sv @@
// ----------------------------------------------------------------------------
// Column gap character segmenter package
// Widths, reset values and sizing defaults shared by the segmenter modules.
// ----------------------------------------------------------------------------
`default_nettype none

package cgcs_pkg;

	// Default coordinate width of rows and columns.
	localparam int COORD_BITS_DEF = 12;

	// Width and reset value of the gap limit register.
	localparam int GAP_BITS = 8;
	localparam logic [GAP_BITS-1:0] GAP_RESET = 8'd4;

	// Default depth of the column record queue between front and back.
	localparam int QUEUE_DEPTH_DEF = 2;

endpackage

`default_nettype wire

@@ rtl/core/cgcs_front.sv @@
// ----------------------------------------------------------------------------
// Column gap character segmenter: front end
// Accepts pixels, tracks the ink extent of the current column and hands a
// column record to the queue at every column end.
// ----------------------------------------------------------------------------
`default_nettype none

module cgcs_front #(
	parameter int COORD_BITS = 12
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic                    pixel,
	input  logic [COORD_BITS-1:0]   row,
	input  logic [COORD_BITS-1:0]   column,
	input  logic                    column_last,
	input  logic                    word_last,
	input  logic                    q_full,
	output logic                    q_push,
	output logic [3*COORD_BITS+2:0] q_wdata
);

	logic                  ink_q;
	logic [COORD_BITS-1:0] top_q;
	logic [COORD_BITS:0]   bottom_q;

	logic                  accept;
	logic                  col_end;
	logic                  ink_now;
	logic [COORD_BITS-1:0] top_now;
	logic [COORD_BITS:0]   bottom_now;

	// A transfer needs room in the queue.
	assign in_stall = q_full;
	assign accept   = in_valid & ~in_stall;
	assign col_end  = column_last | word_last;

	// Column extent including the pixel of this transfer.
	assign ink_now    = ink_q | pixel;
	assign top_now    = (pixel && !ink_q) ? row : top_q;
	assign bottom_now = pixel ? ({1'b0, row} + {{COORD_BITS{1'b0}}, 1'b1}) : bottom_q;

	// Record: word end, ink flag, column, top, bottom.
	assign q_push  = accept & col_end;
	assign q_wdata = {word_last, ink_now, column, top_now, bottom_now};

	// Ink flag of the open column; cleared at each column end.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ink_q <= 1'b0;
		end else if (accept) begin
			ink_q <= col_end ? 1'b0 : ink_now;
		end
	end

	// Column extent payload.
	always_ff @(posedge clk) begin
		if (accept) begin
			top_q    <= top_now;
			bottom_q <= bottom_now;
		end
	end

endmodule

`default_nettype wire

@@ rtl/core/cgcs_queue.sv @@
// ----------------------------------------------------------------------------
// Column gap character segmenter: record queue
// Small register FIFO that decouples the pixel front end from the character
// back end.
// ----------------------------------------------------------------------------
`default_nettype none

`include "column_gap_character_segmenter_unit_defines.svh"

module cgcs_queue #(
	parameter int WIDTH = 39,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             full,
	output logic             empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full  = (count_q == CNT_W'(DEPTH));
	assign empty = (count_q == '0);
	assign rdata = slot_q[rd_ptr_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Storage slots.
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= wdata;
		end
	end

	`CGCS_ASSERT_NOW(a_no_push_full, push, !full, "queue written while full")
	`CGCS_ASSERT_NOW(a_no_pop_empty, pop, !empty, "queue read while empty")
	`CGCS_ASSERT_NOW(a_count_range, 1'b1, count_q <= CNT_W'(DEPTH), "queue count overflow")

endmodule

`default_nettype wire

@@ rtl/core/cgcs_back.sv @@
// ----------------------------------------------------------------------------
// Column gap character segmenter: back end
// Takes column records, opens, widens and closes characters, and holds each
// finished box in an output register until it is transferred.
// ----------------------------------------------------------------------------
`default_nettype none

`include "column_gap_character_segmenter_unit_defines.svh"

module cgcs_back #(
	parameter int COORD_BITS = 12
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [cgcs_pkg::GAP_BITS-1:0] gap_limit,
	input  logic [3*COORD_BITS+2:0]       q_rdata,
	input  logic                          q_empty,
	output logic                          q_pop,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [COORD_BITS-1:0]         box_left,
	output logic [COORD_BITS:0]           box_right,
	output logic [COORD_BITS-1:0]         box_top,
	output logic [COORD_BITS:0]           box_bottom
);

	import cgcs_pkg::*;

	localparam int SUM_W = ((COORD_BITS > GAP_BITS) ? COORD_BITS : GAP_BITS) + 1;

	// Record fields.
	logic                  rec_word_end;
	logic                  rec_ink;
	logic [COORD_BITS-1:0] rec_col;
	logic [COORD_BITS-1:0] rec_top;
	logic [COORD_BITS:0]   rec_bottom;

	// Open character.
	logic                  open_q;
	logic [COORD_BITS-1:0] left_q;
	logic [COORD_BITS-1:0] right_q;
	logic [COORD_BITS-1:0] top_q;
	logic [COORD_BITS:0]   bottom_q;

	// Output register.
	logic                  out_valid_q;
	logic [COORD_BITS-1:0] out_left_q;
	logic [COORD_BITS:0]   out_right_q;
	logic [COORD_BITS-1:0] out_top_q;
	logic [COORD_BITS:0]   out_bottom_q;

	logic                  out_free;
	logic                  gap_exceeded;
	logic                  emit_close;
	logic                  emit_end;
	logic                  emit;
	logic [COORD_BITS-1:0] new_left;
	logic [COORD_BITS-1:0] new_top;
	logic [COORD_BITS:0]   new_bottom;
	logic [COORD_BITS-1:0] box_left_d;
	logic [COORD_BITS:0]   box_right_d;
	logic [COORD_BITS-1:0] box_top_d;
	logic [COORD_BITS:0]   box_bottom_d;

	assign {rec_word_end, rec_ink, rec_col, rec_top, rec_bottom} = q_rdata;

	// A record is taken when the output register is free or drains now.
	assign out_free = ~out_valid_q | ~out_stall;
	assign q_pop    = ~q_empty & out_free;

	// Gap test against the last inky column.
	assign gap_exceeded = SUM_W'(rec_col) > (SUM_W'(right_q) + SUM_W'(gap_limit));

	// Box after an inky column opens or widens the character.
	assign new_left   = open_q ? left_q : rec_col;
	assign new_top    = (open_q && !(rec_top < top_q)) ? top_q : rec_top;
	assign new_bottom = (open_q && !(rec_bottom > bottom_q)) ? bottom_q : rec_bottom;

	// Emission: a blank column past the gap closes; word end flushes.
	assign emit_close = ~rec_ink & open_q & gap_exceeded;
	assign emit_end   = rec_word_end & (rec_ink | open_q) & ~emit_close;
	assign emit       = emit_close | emit_end;

	assign box_left_d   = rec_ink ? new_left : left_q;
	assign box_top_d    = rec_ink ? new_top : top_q;
	assign box_bottom_d = rec_ink ? new_bottom : bottom_q;
	assign box_right_d  = emit_close ? {1'b0, rec_col}
	                                 : ({1'b0, rec_col} + {{COORD_BITS{1'b0}}, 1'b1});

	// Character open flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q <= 1'b0;
		end else if (q_pop) begin
			priority if (rec_word_end || emit_close) begin
				open_q <= 1'b0;
			end else if (rec_ink) begin
				open_q <= 1'b1;
			end else begin
				open_q <= open_q;
			end
		end
	end

	// Character extent payload.
	always_ff @(posedge clk) begin
		if (q_pop && rec_ink) begin
			left_q   <= new_left;
			right_q  <= rec_col;
			top_q    <= new_top;
			bottom_q <= new_bottom;
		end
	end

	// Output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= q_pop & emit;
		end
	end

	// Output payload.
	always_ff @(posedge clk) begin
		if (q_pop && emit) begin
			out_left_q   <= box_left_d;
			out_right_q  <= box_right_d;
			out_top_q    <= box_top_d;
			out_bottom_q <= box_bottom_d;
		end
	end

	assign out_valid  = out_valid_q;
	assign box_left   = out_left_q;
	assign box_right  = out_right_q;
	assign box_top    = out_top_q;
	assign box_bottom = out_bottom_q;

	`CGCS_ASSERT_NOW(a_hold_blocks_pop, out_valid_q && out_stall, !q_pop,
		"record taken while a box is held")
	`CGCS_ASSERT_NEXT(a_word_end_closes, q_pop && rec_word_end, !open_q,
		"character still open after word end")
	`CGCS_ASSERT_NEXT(a_blank_idle_no_box, q_pop && !rec_ink && !open_q, !out_valid_q,
		"box produced with no open character")

endmodule

`default_nettype wire

@@ rtl/core/column_gap_character_segmenter_unit.sv @@
// A box is presented from the output register after the pixel that ends its
// closing column (or the final pixel of the word) has passed the record queue.
// Throughput: one pixel per cycle; a held box stalls pixels only after the
// column record queue fills (two records by default).
// Reset clears the column, character, queue and output state and loads the
// gap limit with 4.
// ----------------------------------------------------------------------------
// Column gap character segmenter top level
// Splits a word box into character boxes by blank column gaps.
// ----------------------------------------------------------------------------
`default_nettype none

module column_gap_character_segmenter_unit #(
	parameter int COORD_BITS  = cgcs_pkg::COORD_BITS_DEF,
	parameter int QUEUE_DEPTH = cgcs_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [cgcs_pkg::GAP_BITS-1:0] cfg_wdata,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          pixel,
	input  logic [COORD_BITS-1:0]         row,
	input  logic [COORD_BITS-1:0]         column,
	input  logic                          column_last,
	input  logic                          word_last,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [COORD_BITS-1:0]         box_left,
	output logic [COORD_BITS:0]           box_right,
	output logic [COORD_BITS-1:0]         box_top,
	output logic [COORD_BITS:0]           box_bottom
);

	import cgcs_pkg::*;

	localparam int REC_W = 3 * COORD_BITS + 3;

	logic [GAP_BITS-1:0] gap_limit_q;
	logic                q_push;
	logic                q_pop;
	logic                q_full;
	logic                q_empty;
	logic [REC_W-1:0]    q_wdata;
	logic [REC_W-1:0]    q_rdata;

	// Gap limit register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gap_limit_q <= GAP_RESET;
		end else if (cfg_we) begin
			gap_limit_q <= cfg_wdata;
		end
	end

	// Pixel front end.
	cgcs_front #(
		.COORD_BITS(COORD_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.pixel      (pixel),
		.row        (row),
		.column     (column),
		.column_last(column_last),
		.word_last  (word_last),
		.q_full     (q_full),
		.q_push     (q_push),
		.q_wdata    (q_wdata)
	);

	// Column record queue.
	cgcs_queue #(
		.WIDTH(REC_W),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (q_push),
		.wdata (q_wdata),
		.pop   (q_pop),
		.rdata (q_rdata),
		.full  (q_full),
		.empty (q_empty)
	);

	// Character back end.
	cgcs_back #(
		.COORD_BITS(COORD_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.gap_limit (gap_limit_q),
		.q_rdata   (q_rdata),
		.q_empty   (q_empty),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.box_left  (box_left),
		.box_right (box_right),
		.box_top   (box_top),
		.box_bottom(box_bottom)
	);

endmodule

`default_nettype wire

@@ tb/column_gap_character_segmenter_unit_test.sv @@
// ----------------------------------------------------------------------------
// Column gap character segmenter testbench
// Streams word boxes of binarized pixels into the segmenter, predicts every
// character box from a behavioral copy of the segmenting rules, and checks
// each box the block emits against it. Both sides idle and stall at random.
// ----------------------------------------------------------------------------
`default_nettype none

module column_gap_character_segmenter_unit_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int COORD_W = cgcs_pkg::COORD_BITS_DEF;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int SETTLE_CYCLES = 8;
	localparam int LONG_HOLD = 300;

	typedef struct packed {
		logic [COORD_W-1:0] left_col;
		logic [COORD_W:0]   right_col;
		logic [COORD_W-1:0] top_row;
		logic [COORD_W:0]   bottom_row;
	} char_box_t;

	logic                          clk;
	logic                          arst_n;
	logic                          cfg_we;
	logic [cgcs_pkg::GAP_BITS-1:0] cfg_wdata;
	logic                          in_valid;
	logic                          in_stall;
	logic                          pixel;
	logic [COORD_W-1:0]            row;
	logic [COORD_W-1:0]            column;
	logic                          column_last;
	logic                          word_last;
	logic                          out_valid;
	logic                          out_stall;
	logic [COORD_W-1:0]            box_left;
	logic [COORD_W:0]              box_right;
	logic [COORD_W-1:0]            box_top;
	logic [COORD_W:0]              box_bottom;

	// Predicted segmenter state and configuration.
	logic [cgcs_pkg::GAP_BITS-1:0] gap_setting = cgcs_pkg::GAP_RESET;
	logic                          col_inked   = 1'b0;
	logic [COORD_W-1:0]            col_top     = '0;
	logic [COORD_W:0]              col_bottom  = '0;
	logic                          char_active = 1'b0;
	logic [COORD_W-1:0]            char_left   = '0;
	logic [COORD_W:0]              char_right  = '0;
	logic [COORD_W-1:0]            char_top    = '0;
	logic [COORD_W:0]              char_bottom = '0;

	char_box_t pending_boxes[$];

	int  error_count   = 0;
	int  sent_items    = 0;
	int  checked_boxes = 0;
	int  gap_writes    = 0;
	int  cycle_count   = 0;
	int  hold_cycles   = 0;
	bit  steady_in     = 1'b0;
	bit  steady_out    = 1'b0;

	column_gap_character_segmenter_unit DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.pixel       (pixel),
		.row         (row),
		.column      (column),
		.column_last (column_last),
		.word_last   (word_last),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.box_left    (box_left),
		.box_right   (box_right),
		.box_top     (box_top),
		.box_bottom  (box_bottom)
	);

	// Clock generation.
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watchdog on the total run length.
	initial begin : watchdog
		forever begin
			@(posedge clk);
			cycle_count++;
			if (cycle_count >= CYCLE_LIMIT) begin
				$display("%0t: run timed out after %0d cycles", $time, cycle_count);
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

	// Idle lengths: mostly none or short, now and then long.
	function automatic int pick_idle_length();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 60)
			return 0;
		else if (roll < 90)
			return $urandom_range(1, 3);
		else if (roll < 98)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// Output side: random stalls, plus a long hold when a test asks for one.
	initial begin : output_side
		int stall_left;
		stall_left = 0;
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_cycles > 0) begin
				out_stall <= 1'b1;
				hold_cycles--;
			end else if (stall_left > 0) begin
				out_stall <= 1'b1;
				stall_left--;
			end else begin
				stall_left = steady_out ? 0 : pick_idle_length();
				if (stall_left > 0) begin
					out_stall <= 1'b1;
					stall_left--;
				end else begin
					out_stall <= 1'b0;
				end
			end
		end
	end

	task automatic clear_character();
		char_active = 1'b0;
		char_left   = '0;
		char_right  = '0;
		char_top    = '0;
		char_bottom = '0;
	endtask

	task automatic clear_column();
		col_inked  = 1'b0;
		col_top    = '0;
		col_bottom = '0;
	endtask

	task automatic push_box(input logic [COORD_W:0] right_edge);
		char_box_t box;
		box.left_col   = char_left;
		box.right_col  = right_edge;
		box.top_row    = char_top;
		box.bottom_row = char_bottom;
		pending_boxes.push_back(box);
	endtask

	// Applies one pixel transfer to the predicted state and queues any box it closes.
	task automatic segment_pixel(input logic ink, input logic [COORD_W-1:0] r,
			input logic [COORD_W-1:0] c, input logic col_end, input logic word_end);
		bit emitted;
		emitted = 1'b0;
		if (ink) begin
			if (!col_inked)
				col_top = r;
			col_inked  = 1'b1;
			col_bottom = {1'b0, r} + 1'b1;
		end
		if (col_end || word_end) begin
			if (col_inked) begin
				if (!char_active) begin
					// The gap is counted from the last inked column, here the opening one.
					char_active = 1'b1;
					char_left   = c;
					char_right  = {1'b0, c};
					char_top    = col_top;
					char_bottom = col_bottom;
				end else begin
					char_right = {1'b0, c};
					if (col_top < char_top)
						char_top = col_top;
					if (col_bottom > char_bottom)
						char_bottom = col_bottom;
				end
			end else if (char_active &&
					int'(c) > int'(char_right) + int'(gap_setting)) begin
				push_box({1'b0, c});
				emitted = 1'b1;
				clear_character();
			end
			clear_column();
		end
		// Word end flushes a character that is still open.
		if (word_end) begin
			if (char_active && !emitted)
				push_box({1'b0, c} + 1'b1);
			clear_character();
			clear_column();
		end
	endtask

	// Input monitor: predict on every accepted transfer.
	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall)
			segment_pixel(pixel, row, column, column_last, word_last);
	end

	task automatic report_field(input string name, input logic [15:0] expected,
			input logic [15:0] actual);
		if (expected !== actual) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d",
				$time, name, expected, actual);
			error_count++;
		end
	endtask

	// Output checker: every box transfer is compared with the oldest prediction.
	always @(posedge clk) begin
		char_box_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_boxes.size() == 0) begin
				$display("%0t: unexpected box, expected none, actual %0d %0d %0d %0d",
					$time, box_left, box_right, box_top, box_bottom);
				error_count++;
			end else begin
				want = pending_boxes.pop_front();
				report_field("box_left", 16'(want.left_col), 16'(box_left));
				report_field("box_right", 16'(want.right_col), 16'(box_right));
				report_field("box_top", 16'(want.top_row), 16'(box_top));
				report_field("box_bottom", 16'(want.bottom_row), 16'(box_bottom));
				checked_boxes++;
			end
		end
	end

	// Offers one pixel after a random gap and returns at the edge it is taken.
	task automatic send_pixel(input logic ink, input logic [COORD_W-1:0] r,
			input logic [COORD_W-1:0] c, input logic col_end, input logic word_end);
		int gap;
		gap = steady_in ? 0 : pick_idle_length();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid    <= 1'b1;
		pixel       <= ink;
		row         <= r;
		column      <= c;
		column_last <= col_end;
		word_last   <= word_end;
		do
			@(posedge clk);
		while (in_stall);
		sent_items++;
	endtask

	// Stops offering pixels and waits until every predicted box has come out.
	task automatic drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_boxes.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_gap_limit(input logic [cgcs_pkg::GAP_BITS-1:0] value);
		drain_results();
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		gap_setting = value;
		gap_writes++;
	endtask

	// One word box in column-major order, inked and blank columns in runs.
	task automatic send_word(input int n_cols, input int n_rows, input bit scramble,
			input bit cut_short);
		logic [COORD_W-1:0] col_base;
		logic [COORD_W-1:0] row_base;
		logic [COORD_W-1:0] c;
		int ink_run;
		int blank_run;
		int rows_here;
		bit inky;
		bit final_col;
		col_base = ($urandom_range(0, 2) == 0) ? COORD_W'($urandom_range(0, 4095))
			: COORD_W'($urandom_range(0, 200));
		row_base = ($urandom_range(0, 2) == 0) ? COORD_W'($urandom_range(0, 4095))
			: COORD_W'($urandom_range(0, 100));
		ink_run = 0;
		blank_run = $urandom_range(0, 2);
		for (int i = 0; i < n_cols; i++) begin
			if (ink_run == 0 && blank_run == 0) begin
				ink_run = $urandom_range(1, 4);
				blank_run = (gap_setting < 10) ? $urandom_range(0, gap_setting + 3)
					: $urandom_range(0, 12);
			end
			inky = (ink_run > 0);
			if (inky)
				ink_run--;
			else
				blank_run--;
			c = scramble ? COORD_W'($urandom_range(0, 40)) : col_base + COORD_W'(i);
			final_col = (i == n_cols - 1);
			// A cut-short final column ends on the word mark alone.
			rows_here = (cut_short && final_col) ? $urandom_range(1, n_rows) : n_rows;
			for (int j = 0; j < rows_here; j++)
				send_pixel(inky && ($urandom_range(0, 2) != 0), row_base + COORD_W'(j), c,
					(j == rows_here - 1) && !(cut_short && final_col),
					final_col && (j == rows_here - 1));
		end
	endtask

	// Opening, widening, out-of-order rows and columns, and word end at gap 4.
	task automatic test_reset_gap_rules();
		send_pixel(1'b1, 12'd4095, 12'd0, 1'b0, 1'b0);
		send_pixel(1'b1, 12'd0, 12'd0, 1'b1, 1'b0);
		send_pixel(1'b0, 12'd0, 12'd2, 1'b1, 1'b0);
		send_pixel(1'b1, 12'd7, 12'd3, 1'b1, 1'b0);
		send_pixel(1'b0, 12'd4095, 12'd1, 1'b1, 1'b0);
		send_pixel(1'b0, 12'd0, 12'd8, 1'b1, 1'b0);
		send_pixel(1'b1, 12'd100, 12'd4095, 1'b0, 1'b1);
		send_pixel(1'b0, 12'd0, 12'd5, 1'b0, 1'b1);
		send_pixel(1'b1, 12'd2048, 12'd10, 1'b1, 1'b0);
		send_pixel(1'b0, 12'd4095, 12'd15, 1'b1, 1'b1);
		drain_results();
	endtask

	// The smallest and the largest gap limit.
	task automatic test_gap_extremes();
		set_gap_limit(8'd0);
		send_pixel(1'b1, 12'd1, 12'd20, 1'b1, 1'b0);
		send_pixel(1'b0, 12'd0, 12'd21, 1'b1, 1'b0);
		send_pixel(1'b0, 12'd0, 12'd22, 1'b1, 1'b1);
		set_gap_limit(8'd255);
		send_pixel(1'b1, 12'd9, 12'd100, 1'b1, 1'b0);
		send_pixel(1'b0, 12'd0, 12'd355, 1'b1, 1'b0);
		send_pixel(1'b0, 12'd0, 12'd356, 1'b1, 1'b0);
		send_pixel(1'b1, 12'd4095, 12'd4000, 1'b1, 1'b0);
		send_pixel(1'b0, 12'd0, 12'd4095, 1'b1, 1'b0);
		send_pixel(1'b0, 12'd0, 12'd4095, 1'b0, 1'b1);
		drain_results();
	endtask

	// Long output hold while pixels keep coming, so the input side backs up.
	task automatic test_output_hold();
		set_gap_limit(8'd0);
		steady_in = 1'b1;
		hold_cycles = LONG_HOLD;
		for (int c = 0; c < 40; c++)
			send_pixel(c % 2 == 0, 12'd5, COORD_W'(300 + c), 1'b1, c == 39);
		steady_in = 1'b0;
		drain_results();
	endtask

	// Well-formed words with random content under a range of gap limits.
	task automatic test_random_words(input int item_target);
		int word_no;
		int pick;
		int n_cols;
		int n_rows;
		word_no = 0;
		while (sent_items < item_target) begin
			if (word_no % 6 == 0) begin
				pick = $urandom_range(0, 7);
				set_gap_limit(pick == 6 ? 8'd255 :
					pick == 7 ? 8'($urandom_range(0, 255)) : 8'(pick));
			end
			steady_in  = ($urandom_range(0, 3) == 0);
			steady_out = ($urandom_range(0, 3) == 0);
			n_cols = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 64)
				: $urandom_range(3, 24);
			n_rows = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 16)
				: $urandom_range(1, 6);
			send_word(n_cols, n_rows, 1'b0, $urandom_range(0, 4) == 0);
			word_no++;
		end
		steady_in  = 1'b0;
		steady_out = 1'b0;
		drain_results();
	endtask

	// Fully random pixels, then words whose columns come in random order.
	task automatic test_noise(input int item_count);
		int stop_at;
		stop_at = sent_items + item_count;
		set_gap_limit(8'd3);
		for (int i = 0; i < item_count / 2; i++)
			send_pixel(1'($urandom_range(0, 1)), COORD_W'($urandom_range(0, 4095)),
				COORD_W'($urandom_range(0, 4095)), $urandom_range(0, 3) == 0,
				$urandom_range(0, 15) == 0);
		while (sent_items < stop_at)
			send_word($urandom_range(3, 12), $urandom_range(1, 4), 1'b1,
				1'($urandom_range(0, 1)));
		drain_results();
	endtask

	// Test sequence.
	initial begin
		arst_n      <= 1'b0;
		cfg_we      <= 1'b0;
		cfg_wdata   <= '0;
		in_valid    <= 1'b0;
		pixel       <= 1'b0;
		row         <= '0;
		column      <= '0;
		column_last <= 1'b0;
		word_last   <= 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		test_reset_gap_rules();
		test_gap_extremes();
		test_output_hold();
		test_random_words(1300);
		test_noise(300);

		$display("Segmented %0d pixel transfers into %0d checked character boxes.",
			sent_items, checked_boxes);
		$display("Gap limit written %0d times, extremes included, with a %0d-cycle hold.",
			gap_writes, LONG_HOLD);
		if (error_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

`default_nettype wire

@@ filelist.f @@
+incdir+rtl/core
rtl/core/cgcs_pkg.sv
rtl/core/cgcs_front.sv
rtl/core/cgcs_queue.sv
rtl/core/cgcs_back.sv
rtl/core/column_gap_character_segmenter_unit.sv
tb/column_gap_character_segmenter_unit_test.sv
